[rtl/ecd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg
// Types, constants and saturating fixed-point helpers of the Euler converter.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned GAMMA_W    = 19;
  localparam int unsigned NLANE      = 3;
  localparam int unsigned DIV_STEPS  = 16;             // two quotient bits each
  localparam int unsigned DIV_LAT    = DIV_STEPS + 2;  // entry + steps + sign fix
  localparam int unsigned RESULT_LAT = DIV_LAT + 7;

  typedef enum logic [1:0] {
    KIND_P2C  = 2'd0,
    KIND_C2P  = 2'd1,
    KIND_FLUX = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] in_density;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_energy;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_density;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_energy;
    logic               clamped;
  } out_t;

  // value plus saturation note
  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } res_t;

  // one divider lane in flight
  typedef struct packed {
    logic        dz;
    logic        ovf;
    logic        neg;
    logic        dneg;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
  } dlane_t;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  function automatic res_t sat64(input logic signed [63:0] x);
    res_t r;
    if (x > S32_MAX) begin
      r.sat = 1'b1;
      r.v   = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r.sat = 1'b1;
      r.v   = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.v   = x[31:0];
    end
    return r;
  endfunction

  // floor(a*b / 2^frac)
  function automatic res_t fx_mul(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input int unsigned frac);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> frac);
  endfunction

  function automatic res_t fx_add(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic res_t fx_sub(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] fx_half(input logic signed [31:0] a);
    return a >>> 1;
  endfunction

endpackage

[rtl/ecd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_div
// Pipelined signed fixed-point divider, three lanes, trunc toward zero,
// saturating; two restoring quotient bits per stage.
// ----------------------------------------------------------------------------
module ecd_div import ecd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] num_i [NLANE],
  input  logic signed [31:0] den_i [NLANE],
  output logic               valid_o,
  output res_t               res_o [NLANE]
);

  dlane_t st_q [DIV_STEPS+1][NLANE];
  dlane_t st_d [DIV_STEPS+1][NLANE];
  logic   vld_q [DIV_STEPS+2];
  res_t   res_q [NLANE];
  res_t   res_d [NLANE];

  always_comb begin
    logic [31:0]             nm;
    logic [31:0]             dm;
    logic [31+FRAC_BITS:0]   wide;
    logic [32:0]             r2;
    dlane_t                  w;
    for (int l = 0; l < NLANE; l++) begin
      nm   = num_i[l][31] ? 32'(-num_i[l]) : num_i[l];
      dm   = den_i[l][31] ? 32'(-den_i[l]) : den_i[l];
      wide = {nm, {FRAC_BITS{1'b0}}};
      st_d[0][l].rem  = 32'(wide[31+FRAC_BITS:32]);
      st_d[0][l].num  = wide[31:0];
      st_d[0][l].den  = dm;
      st_d[0][l].dz   = (dm == 32'd0);
      st_d[0][l].ovf  = (32'(wide[31+FRAC_BITS:32]) >= dm);
      st_d[0][l].neg  = num_i[l][31] ^ den_i[l][31];
      st_d[0][l].dneg = num_i[l][31];
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        w = st_q[s-1][l];
        for (int b = 0; b < 2; b++) begin
          r2 = {w.rem, w.num[31]};
          if (r2 >= {1'b0, w.den}) begin
            w.rem = 32'(r2 - {1'b0, w.den});
            w.num = {w.num[30:0], 1'b1};
          end else begin
            w.rem = r2[31:0];
            w.num = {w.num[30:0], 1'b0};
          end
        end
        st_d[s][l] = w;
      end
    end
    for (int l = 0; l < NLANE; l++) begin
      w = st_q[DIV_STEPS][l];
      if (w.dz) begin
        res_d[l].sat = 1'b1;
        res_d[l].v   = w.dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (w.ovf) begin
        res_d[l].sat = 1'b1;
        res_d[l].v   = w.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (!w.neg) begin
        res_d[l].sat = w.num[31];
        res_d[l].v   = w.num[31] ? 32'sh7FFF_FFFF : signed'(w.num);
      end else begin
        res_d[l].sat = (w.num > 32'h8000_0000);
        res_d[l].v   = (w.num > 32'h8000_0000) ? 32'sh8000_0000 : signed'(-w.num);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STEPS + 2; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < DIV_STEPS + 2; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    res_q <= res_d;
  end

  assign valid_o = vld_q[DIV_STEPS+1];
  assign res_o   = res_q;

endmodule

[rtl/euler_state_conversion_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_state_conversion_top
// 2D Euler cell converter: primitive/conservative conversion and x flux,
// signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input word on item_i is taken at a rising edge with start high and busy
//   low. busy stays low: the pipeline takes a new cell every clock.
//   Each result word appears on result_o for exactly one cycle with done_o
//   high; the receiver cannot hold it off, so nothing ever stalls.
//   Throughput is one cell per clock. The depth is set by the divider (entry
//   stage, 16 stages of two quotient bits, sign fix) plus three multiply/add
//   stages before it and three after it. gamma is written through
//   cfg_we_i/cfg_wdata_i; the user must do so only while no cell is in
//   flight, which the block does not enforce. gm1 = gamma - 1 is derived
//   from the register combinationally. Reset clears all valid bits and loads
//   gamma with 1.4; data regs keep X. kind 3 yields an all-zero word.
// ----------------------------------------------------------------------------
module euler_state_conversion_top import ecd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_t                item_i,
  output logic               done_o,
  output out_t               result_o,
  input  logic               cfg_we_i,
  input  logic [GAMMA_W-1:0] cfg_wdata_i
);

  localparam logic [63:0] GAMMA_RAW = ((64'd7 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [GAMMA_W-1:0] GAMMA_RST = GAMMA_RAW[GAMMA_W-1:0];
  localparam logic [63:0] FLOOR_RAW = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic signed [31:0] FLOOR_FX =
    (FLOOR_RAW == 64'd0) ? 32'sd1 : signed'(FLOOR_RAW[31:0]);
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] a, b, c, d;
    res_t uu, vv, ab, ac;
  } stb_t;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] a, b, c, d;
    res_t s, ab, ac;
    logic fl;
  } stc_t;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] a, b, c, d, s, ek;
    res_t ab, ac, mb, mc;
    logic fl;
  } std_t;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] a, b, d, q0, q1;
    res_t ab, ac, mc, e, diff, o1f;
    logic fl;
  } ste_t;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] a, b, q0, q1;
    res_t ab, ac, mc, e, o1f, p, t;
    logic fl;
  } stf_t;

  logic [GAMMA_W-1:0] gamma_q;
  logic signed [31:0] gm1;

  logic vA_q, vB_q, vC_q, vD_q, vE_q, vF_q, done_q;
  in_t  a_q;
  stb_t b_q, b_d;
  stc_t c_q, c_d;
  std_t d_q, d_d;
  std_t side_q [DIV_LAT];
  ste_t e_q, e_d;
  stf_t f_q, f_d;
  out_t out_q, out_d;

  logic               div_vld;
  logic signed [31:0] div_num [NLANE];
  logic signed [31:0] div_den [NLANE];
  res_t               div_res [NLANE];
  logic               vE_d_unused_guard;

  assign gm1  = signed'(32'(gamma_q)) - ONE_FX;
  assign busy = 1'b0;

  // stage B: first products
  always_comb begin
    b_d.kind = a_q.kind;
    b_d.a = a_q.in_density;
    b_d.b = a_q.in_x;
    b_d.c = a_q.in_y;
    b_d.d = a_q.in_energy;
    b_d.uu = fx_mul(a_q.in_x, a_q.in_x, FRAC_BITS);
    b_d.vv = fx_mul(a_q.in_y, a_q.in_y, FRAC_BITS);
    b_d.ab = fx_mul(a_q.in_density, a_q.in_x, FRAC_BITS);
    b_d.ac = fx_mul(a_q.in_density, a_q.in_y, FRAC_BITS);
  end

  // stage C: squared speed sum
  always_comb begin
    c_d.kind = b_q.kind;
    c_d.a = b_q.a;
    c_d.b = b_q.b;
    c_d.c = b_q.c;
    c_d.d = b_q.d;
    c_d.s = fx_add(b_q.uu.v, b_q.vv.v);
    c_d.ab = b_q.ab;
    c_d.ac = b_q.ac;
    c_d.fl = b_q.uu.sat | b_q.vv.sat | c_d.s.sat;
  end

  // stage D: kinetic energy and momentum products
  always_comb begin
    res_t rs;
    rs = fx_mul(c_q.a, c_q.s.v, FRAC_BITS);
    d_d.kind = c_q.kind;
    d_d.a = c_q.a;
    d_d.b = c_q.b;
    d_d.c = c_q.c;
    d_d.d = c_q.d;
    d_d.s = c_q.s.v;
    d_d.ek = fx_half(rs.v);
    d_d.ab = c_q.ab;
    d_d.ac = c_q.ac;
    d_d.mb = fx_mul(c_q.ab.v, c_q.b, FRAC_BITS);
    d_d.mc = fx_mul(c_q.ab.v, c_q.c, FRAC_BITS);
    unique case (c_q.kind)
      KIND_P2C:  d_d.fl = c_q.fl | rs.sat | c_q.ab.sat | c_q.ac.sat;
      KIND_C2P:  d_d.fl = c_q.fl;
      KIND_FLUX: d_d.fl = c_q.fl | rs.sat | c_q.ab.sat | d_d.mb.sat | d_d.mc.sat;
      default:   d_d.fl = 1'b0;
    endcase
  end

  // divider lanes: kind 1 divides by density, otherwise lane 0 does p / gm1
  always_comb begin
    div_vld    = vD_q;
    div_num[0] = (d_q.kind == KIND_C2P) ? d_q.b : d_q.d;
    div_den[0] = (d_q.kind == KIND_C2P) ? d_q.a : gm1;
    div_num[1] = d_q.c;
    div_den[1] = d_q.a;
    div_num[2] = d_q.s;
    div_den[2] = d_q.a;
  end

  ecd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .num_i   (div_num),
    .den_i   (div_den),
    .valid_o (vE_d_unused_guard),
    .res_o   (div_res)
  );

  // stage E: energy sum, internal energy difference, x momentum flux
  always_comb begin
    std_t sd;
    sd = side_q[DIV_LAT-1];
    e_d.kind = sd.kind;
    e_d.a = sd.a;
    e_d.b = sd.b;
    e_d.d = sd.d;
    e_d.q0 = div_res[0].v;
    e_d.q1 = div_res[1].v;
    e_d.ab = sd.ab;
    e_d.ac = sd.ac;
    e_d.mc = sd.mc;
    e_d.e = fx_add(sd.ek, div_res[0].v);
    e_d.diff = fx_sub(sd.d, fx_half(div_res[2].v));
    e_d.o1f = fx_add(sd.mb.v, sd.d);
    unique case (sd.kind)
      KIND_P2C:  e_d.fl = sd.fl | div_res[0].sat | e_d.e.sat;
      KIND_C2P:  e_d.fl = sd.fl | div_res[0].sat | div_res[1].sat | div_res[2].sat
                          | e_d.diff.sat;
      KIND_FLUX: e_d.fl = sd.fl | div_res[0].sat | e_d.e.sat | e_d.o1f.sat;
      default:   e_d.fl = 1'b0;
    endcase
  end

  // stage F: pressure and flux energy sum
  always_comb begin
    f_d.kind = e_q.kind;
    f_d.a = e_q.a;
    f_d.b = e_q.b;
    f_d.q0 = e_q.q0;
    f_d.q1 = e_q.q1;
    f_d.ab = e_q.ab;
    f_d.ac = e_q.ac;
    f_d.mc = e_q.mc;
    f_d.e = e_q.e;
    f_d.o1f = e_q.o1f;
    f_d.p = fx_mul(e_q.diff.v, gm1, FRAC_BITS);
    f_d.t = fx_add(e_q.e.v, e_q.d);
    unique case (e_q.kind)
      KIND_C2P:  f_d.fl = e_q.fl | f_d.p.sat;
      KIND_FLUX: f_d.fl = e_q.fl | f_d.t.sat;
      default:   f_d.fl = e_q.fl;
    endcase
  end

  // output stage: energy flux, clamps, selection
  always_comb begin
    res_t ef;
    logic rneg, pneg;
    ef   = fx_mul(f_q.t.v, f_q.b, FRAC_BITS);
    rneg = f_q.a[31];
    pneg = f_q.p.v[31];
    unique case (f_q.kind)
      KIND_P2C: begin
        out_d.out_density = f_q.a;
        out_d.out_x       = f_q.ab.v;
        out_d.out_y       = f_q.ac.v;
        out_d.out_energy  = f_q.e.v;
        out_d.clamped     = f_q.fl;
      end
      KIND_C2P: begin
        out_d.out_density = rneg ? FLOOR_FX : f_q.a;
        out_d.out_x       = f_q.q0;
        out_d.out_y       = f_q.q1;
        out_d.out_energy  = pneg ? FLOOR_FX : f_q.p.v;
        out_d.clamped     = f_q.fl | rneg | pneg;
      end
      KIND_FLUX: begin
        out_d.out_density = f_q.ab.v;
        out_d.out_x       = f_q.o1f.v;
        out_d.out_y       = f_q.mc.v;
        out_d.out_energy  = ef.v;
        out_d.clamped     = f_q.fl | ef.sat;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
      vA_q    <= 1'b0;
      vB_q    <= 1'b0;
      vC_q    <= 1'b0;
      vD_q    <= 1'b0;
      vE_q    <= 1'b0;
      vF_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) gamma_q <= cfg_wdata_i;
      vA_q   <= start && !busy;
      vB_q   <= vA_q;
      vC_q   <= vB_q;
      vD_q   <= vC_q;
      vE_q   <= vE_d_unused_guard;
      vF_q   <= vE_q;
      done_q <= vF_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= item_i;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    side_q[0] <= d_q;
    for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
    e_q   <= e_d;
    f_q   <= f_d;
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

[rtl/ecd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_chk
// Port-level checker for the Euler converter, bound to the top level.
// ----------------------------------------------------------------------------
module ecd_chk import ecd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic done_o,
  input out_t result_o
);

  logic [5:0] warm_q;
  logic       warm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + 6'd1;
    end
  end

  assign warm = (warm_q >= 6'(RESULT_LAT));

  // one result per accepted word, fixed latency
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start && !busy, RESULT_LAT)))
    else $error("result strobe does not match accepted word");

  // unused kind gives all zeros
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(item_i.kind == KIND_NONE, RESULT_LAT)) |->
    (result_o == '0))
    else $error("unused kind gave nonzero word");

  // primitive to conservative keeps density
  a_rho: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(item_i.kind == KIND_P2C, RESULT_LAT)) |->
    (result_o.out_density == $past(item_i.in_density, RESULT_LAT)))
    else $error("density not passed through");

  // negative density clamps and flags
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o && $past(item_i.kind == KIND_C2P && item_i.in_density[31],
                             RESULT_LAT)) |->
    (result_o.clamped && !result_o.out_density[31]))
    else $error("negative density not clamped");

endmodule

bind euler_state_conversion_top ecd_chk u_ecd_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler cell converter: random and directed
// cells, gamma swept across its range, results checked against a
// behavioral model of the fixed-point datapath.
// ----------------------------------------------------------------------------
module tb;
  import ecd_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [63:0] I32MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] I32MIN = -64'sh8000_0000;
  localparam logic signed [63:0] ONE = 64'sd1 << FRAC;
  // nearest fixed-point value to 1e-5, at least one LSB
  localparam logic signed [63:0] FLOOR_V = ((ONE + 50000) / 100000) > 0 ?
                                           ((ONE + 50000) / 100000) : 64'sd1;

  // converter model; sat set by any saturation during one cell
  class cell_scoreboard;
    logic [GAMMA_W-1:0] gamma;
    bit sat;
    out_t pending[$];
    int errors;

    function new();
      gamma = GAMMA_W'(((64'sd7 << FRAC) + 2) / 5);
      errors = 0;
    endfunction

    function logic signed [63:0] clip(logic signed [63:0] v);
      if (v > I32MAX) begin
        sat = 1;
        return I32MAX;
      end
      if (v < I32MIN) begin
        sat = 1;
        return I32MIN;
      end
      return v;
    endfunction

    function logic signed [63:0] mul(logic signed [63:0] a, logic signed [63:0] b);
      return clip((a * b) >>> FRAC);
    endfunction

    function logic signed [63:0] div(logic signed [63:0] a, logic signed [63:0] b);
      if (b == 0) begin
        sat = 1;
        return a >= 0 ? I32MAX : I32MIN;
      end
      return clip((a * ONE) / b);  // SV signed divide truncates toward zero
    endfunction

    function logic signed [63:0] kin(logic signed [63:0] r, logic signed [63:0] u,
                                     logic signed [63:0] v);
      return mul(r, clip(mul(u, u) + mul(v, v))) >>> 1;
    endfunction

    function void note_cell(in_t w);
      logic signed [63:0] r, u, v, p, gm1, o0, o1, o2, o3, ek, m, en;
      out_t e;
      r = 64'(w.in_density);
      u = 64'(w.in_x);
      v = 64'(w.in_y);
      p = 64'(w.in_energy);
      sat = 0;
      gm1 = clip(64'(gamma) - ONE);
      o0 = 0; o1 = 0; o2 = 0; o3 = 0;
      case (w.kind)
        KIND_P2C: begin
          ek = kin(r, u, v);
          o0 = r;
          o1 = mul(r, u);
          o2 = mul(r, v);
          o3 = clip(ek + div(p, gm1));
        end
        KIND_C2P: begin
          ek = div(clip(mul(u, u) + mul(v, v)), r) >>> 1;
          o0 = r;
          o1 = div(u, r);
          o2 = div(v, r);
          o3 = mul(clip(p - ek), gm1);
          if (o0 < 0) begin
            o0 = FLOOR_V;
            sat = 1;
          end
          if (o3 < 0) begin
            o3 = FLOOR_V;
            sat = 1;
          end
        end
        KIND_FLUX: begin
          en = clip(kin(r, u, v) + div(p, gm1));
          m = mul(r, u);
          o0 = m;
          o1 = clip(mul(m, u) + p);
          o2 = mul(m, v);
          o3 = mul(clip(en + p), u);
        end
        default: sat = 0;
      endcase
      e.out_density = o0[31:0];
      e.out_x = o1[31:0];
      e.out_y = o2[31:0];
      e.out_energy = o3[31:0];
      e.clamped = sat;
      pending.push_back(e);
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.out_density !== e.out_density) begin
        $error("out_density exp %h got %h", e.out_density, a.out_density); errors++;
      end
      if (a.out_x !== e.out_x) begin
        $error("out_x exp %h got %h", e.out_x, a.out_x); errors++;
      end
      if (a.out_y !== e.out_y) begin
        $error("out_y exp %h got %h", e.out_y, a.out_y); errors++;
      end
      if (a.out_energy !== e.out_energy) begin
        $error("out_energy exp %h got %h", e.out_energy, a.out_energy); errors++;
      end
      if (a.clamped !== e.clamped) begin
        $error("clamped exp %b got %b", e.clamped, a.clamped); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_t item = '0;
  logic done;
  out_t result;
  logic cfg_we = 0;
  logic [GAMMA_W-1:0] cfg_wdata = '0;
  bit no_gaps = 0;

  cell_scoreboard sb = new();

  always #5 clk = ~clk;

  euler_state_conversion_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .item_i(item),
    .done_o(done), .result_o(result), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  // results are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(result);
  end

  // random value biased toward small magnitudes and the extremes
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'(int'($urandom_range(0, 4)) - 2);
      4, 5: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      default: return 32'(int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  // hold one word on the input until the block takes it; start stays high
  // into the next word when there is no idle cycle between them
  task automatic send_cell(in_t w);
    while (!no_gaps && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    sb.note_cell(w);
  endtask

  task automatic send_rand(int unsigned n);
    in_t w;
    repeat (n) begin
      w.kind = kind_e'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
      w.in_density = rnd_val();
      w.in_x = rnd_val();
      w.in_y = rnd_val();
      w.in_energy = rnd_val();
      send_cell(w);
    end
  endtask

  // gamma may only change with nothing in flight
  task automatic set_gamma(logic [GAMMA_W-1:0] g);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (RESULT_LAT + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.gamma = g;
  endtask

  task automatic send_dir(kind_e k, logic [31:0] r, logic [31:0] u, logic [31:0] v,
                          logic [31:0] p);
    in_t w;
    w.kind = k; w.in_density = r; w.in_x = u; w.in_y = v; w.in_energy = p;
    send_cell(w);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind, extremes, zero density, negative density/pressure
    send_dir(KIND_P2C, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000);
    send_dir(KIND_P2C, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_dir(KIND_P2C, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_dir(KIND_P2C, 0, 0, 0, 0);
    send_dir(KIND_C2P, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0010_0000);
    send_dir(KIND_C2P, 0, 32'h0001_0000, 0, 32'h0001_0000);
    send_dir(KIND_C2P, 0, 32'hFFFF_0000, 0, 0);
    send_dir(KIND_C2P, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_dir(KIND_C2P, 32'h0001_0000, 32'h0004_0000, 0, 32'hFFFF_0000);
    send_dir(KIND_C2P, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_dir(KIND_C2P, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_dir(KIND_FLUX, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_dir(KIND_FLUX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_dir(KIND_FLUX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_dir(KIND_NONE, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);

    // gamma at its extremes, at 1.0 exactly (zero gm1) and random values
    set_gamma(19'd65537);
    send_rand(120);
    set_gamma(19'd262144);
    send_rand(120);
    set_gamma(19'd65536);
    send_dir(KIND_P2C, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_dir(KIND_P2C, 32'h0001_0000, 0, 0, 32'hFFFF_0000);
    send_rand(60);
    set_gamma(19'h7FFFF);
    send_rand(60);
    set_gamma(19'd0);
    send_rand(40);
    set_gamma(19'd91750);
    no_gaps = 1;
    send_rand(300);
    no_gaps = 0;
    repeat (3) begin
      set_gamma(GAMMA_W'($urandom_range(65537, 262144)));
      send_rand(200);
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (RESULT_LAT + 5) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/ecd_pkg.sv
rtl/ecd_div.sv
rtl/euler_state_conversion_top.sv
rtl/ecd_chk.sv
test/tb.sv
